/* src/fpa_pkg.sv */
// fpa_pkg: shared types, constants and helpers for the fixed-size pool allocator
// used by fpa_ram users, fpa_ctrl, fpa_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  // sizing of the pool and of the free stack
  localparam int FREE_DEPTH       = 1024;
  localparam int POOL_OFFSET_BITS = 40;
  localparam int PAGE_BYTES       = 4096;
  localparam int PAGE_LOG2        = $clog2(PAGE_BYTES);
  localparam int SLOT_BYTES       = 8;
  localparam int SLOT_LOG2        = $clog2(SLOT_BYTES);
  localparam int SLOTS_PER_PAGE   = PAGE_BYTES / SLOT_BYTES;

  localparam int STACK_ADDR_W = $clog2(FREE_DEPTH);
  localparam int COUNT_W      = STACK_ADDR_W + 1;
  localparam int OFFSET_W     = POOL_OFFSET_BITS + 1;
  localparam int SUM_W        = POOL_OFFSET_BITS + 2;
  localparam int ADDR_W       = 64;

  // configuration register widths
  localparam int POOL_INDEX_W = 24;
  localparam int ELEM_W       = 21;
  localparam int ALIGN_W      = 4;
  localparam int HEADER_W     = 12;
  localparam int OBJ_W        = ELEM_W + 1;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int STATUS_W     = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_INDEX    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_BYTES = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_LOG2    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTES  = 4'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FRESH     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  // address constants
  localparam logic [ADDR_W-1:0]   REGION_BASE = 64'hFFFF_9000_0000_0000;
  localparam logic [SUM_W-1:0]    POOL_BYTES  = SUM_W'(1) << POOL_OFFSET_BITS;
  localparam logic [OFFSET_W-1:0] PAGE_MASK   = OFFSET_W'(PAGE_BYTES - 1);
  localparam logic [OFFSET_W-1:0] STACK_TOP_OFF =
    OFFSET_W'(POOL_BYTES - SUM_W'(PAGE_BYTES));
  localparam logic [COUNT_W-1:0]  SLOTS_STEP  = COUNT_W'(SLOTS_PER_PAGE);
  localparam logic [COUNT_W-1:0]  FULL_COUNT  = COUNT_W'(FREE_DEPTH);

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] free_address;
  } fpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
    logic                map_request;
    logic [ADDR_W-1:0]   map_address;
  } fpa_result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic cfg_we;
  } fpa_cmd_t;

  // round value up to a multiple of 2^lg
  function automatic logic [OBJ_W-1:0] round_up(input logic [OBJ_W-1:0] value,
                                                input logic [ALIGN_W-1:0] lg);
    logic [OBJ_W-1:0] mask;
    mask = (OBJ_W'(1) << lg) - OBJ_W'(1);
    return (value + mask) & ~mask;
  endfunction

  // reset values
  localparam logic [ELEM_W-1:0]   RST_ELEM      = 21'd64;
  localparam logic [ALIGN_W-1:0]  RST_ALIGN     = 4'd3;
  localparam logic [HEADER_W-1:0] RST_HEADER    = 12'd40;
  localparam logic [OBJ_W-1:0]    RST_OBJ_SIZE  = round_up(OBJ_W'(RST_ELEM), RST_ALIGN);
  localparam logic [OFFSET_W-1:0] RST_NEXT_OFF  =
    OFFSET_W'(round_up(OBJ_W'(RST_HEADER), RST_ALIGN));

endpackage

`default_nettype wire

/* src/fpa_ram.sv */
// fpa_ram: generic simple dual-port ram, one write and one registered read
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/fpa_ctrl.sv */
// fpa_ctrl: two-state sequencer for the pool allocator
// depends on fpa_pkg for the command struct
`timescale 1ns / 1ps
`default_nettype none

module fpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_valid,
  output logic             busy,
  output logic             cfg_ready,
  output logic             done,
  output fpa_pkg::fpa_cmd_t cmd
);
  import fpa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  assign busy       = (state == S_EXEC);
  // no config write in the cycle a request is taken
  assign cfg_ready  = (state == S_IDLE) && !start;
  assign cmd.load   = start && (state == S_IDLE);
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.cfg_we = cfg_valid && cfg_ready;

  // done is registered from the exec state that the accepting edge enters
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing two cycles after accept");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

/* src/fpa_datapath.sv */
// fpa_datapath: config registers, bump pointer, free stack and result register
// depends on fpa_pkg and fpa_ram
`timescale 1ns / 1ps
`default_nettype none

module fpa_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpa_pkg::fpa_cmd_t                    cmd,
  input  fpa_pkg::fpa_req_t                    req,
  input  logic [fpa_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]       cfg_data,
  output fpa_pkg::fpa_result_t                 result
);
  import fpa_pkg::*;

  // configuration and derived values
  logic [ELEM_W-1:0]   element_bytes;
  logic [ALIGN_W-1:0]  align_log2;
  logic [HEADER_W-1:0] header_bytes;
  logic [ADDR_W-1:0]   base_addr;
  logic [OBJ_W-1:0]    object_bytes;

  logic [ELEM_W-1:0]   elem_new;
  logic [ALIGN_W-1:0]  align_new;
  logic [HEADER_W-1:0] header_new;
  logic [ADDR_W-1:0]   base_new;
  logic                cfg_hit;

  // allocator state
  logic [OFFSET_W-1:0] next_offset;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  mapped_slots;

  // values captured at accept
  logic                        req_mode;
  logic [POOL_OFFSET_BITS-1:0] req_offset;
  logic                        empty_q;
  logic                        full_q;
  logic                        stack_map_q;
  logic                        cross_q;
  logic [SUM_W-1:0]            sum_q;
  logic [OFFSET_W-1:0]         page_up_q;
  logic [OFFSET_W-1:0]         stack_page_q;

  logic [OBJ_W:0]              cross_sum;
  logic [POOL_OFFSET_BITS-1:0] stack_rdata;

  // exec stage
  logic [OFFSET_W-1:0] addr_off;
  logic [OFFSET_W-1:0] map_off;
  logic [ADDR_W-1:0]   addr_sum;
  logic [ADDR_W-1:0]   map_sum;
  logic                exhausted;
  logic                push;
  logic                pop;
  logic                fresh;
  fpa_result_t         result_next;

  always_comb begin
    elem_new   = element_bytes;
    align_new  = align_log2;
    header_new = header_bytes;
    base_new   = base_addr;
    cfg_hit    = 1'b1;
    case (cfg_index)
      REG_POOL_INDEX: begin
        base_new = REGION_BASE +
                   (ADDR_W'(cfg_data[POOL_INDEX_W-1:0]) << POOL_OFFSET_BITS);
      end
      REG_ELEMENT_BYTES: elem_new   = cfg_data[ELEM_W-1:0];
      REG_ALIGN_LOG2:    align_new  = cfg_data[ALIGN_W-1:0];
      REG_HEADER_BYTES:  header_new = cfg_data[HEADER_W-1:0];
      default:           cfg_hit    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= RST_ELEM;
      align_log2    <= RST_ALIGN;
      header_bytes  <= RST_HEADER;
      base_addr     <= REGION_BASE;
      object_bytes  <= RST_OBJ_SIZE;
    end else if (cmd.cfg_we && cfg_hit) begin
      element_bytes <= elem_new;
      align_log2    <= align_new;
      header_bytes  <= header_new;
      base_addr     <= base_new;
      object_bytes  <= round_up(OBJ_W'(elem_new), align_new);
    end
  end

  // accept: snapshot flags and precompute offsets
  assign cross_sum = (OBJ_W + 1)'(next_offset[PAGE_LOG2-1:0]) + (OBJ_W + 1)'(object_bytes);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode     <= req.mode;
      req_offset   <= req.free_address[POOL_OFFSET_BITS-1:0];
      empty_q      <= (free_count == '0);
      full_q       <= (free_count >= FULL_COUNT);
      stack_map_q  <= (free_count == mapped_slots);
      cross_q      <= (object_bytes != '0) && (cross_sum > (OBJ_W + 1)'(PAGE_BYTES));
      sum_q        <= SUM_W'(next_offset) + SUM_W'(object_bytes);
      page_up_q    <= (next_offset + PAGE_MASK) & ~PAGE_MASK;
      stack_page_q <= STACK_TOP_OFF - (OFFSET_W'(mapped_slots) << SLOT_LOG2);
    end
  end

  fpa_ram #(
    .WIDTH(POOL_OFFSET_BITS),
    .DEPTH(FREE_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push),
    .waddr(free_count[STACK_ADDR_W-1:0]),
    .wdata(req_offset),
    .re   (cmd.load),
    .raddr(free_count[STACK_ADDR_W-1:0] - STACK_ADDR_W'(1)),
    .rdata(stack_rdata)
  );

  // exec: address adds and result selection
  assign exhausted = (sum_q > POOL_BYTES);
  assign addr_off  = empty_q ? next_offset : OFFSET_W'(stack_rdata);
  assign map_off   = req_mode ? stack_page_q : page_up_q;
  assign addr_sum  = base_addr + ADDR_W'(addr_off);
  assign map_sum   = base_addr + ADDR_W'(map_off);

  assign push  = cmd.exec && req_mode && !full_q;
  assign pop   = cmd.exec && !req_mode && !empty_q;
  assign fresh = cmd.exec && !req_mode && empty_q && !exhausted;

  always_comb begin
    result_next             = '0;
    result_next.status      = ST_FREED;
    if (!req_mode) begin
      if (!empty_q) begin
        result_next.address = addr_sum;
        result_next.status  = ST_REUSED;
      end else if (exhausted) begin
        result_next.status  = ST_EXHAUSTED;
      end else begin
        result_next.address     = addr_sum;
        result_next.status      = ST_FRESH;
        result_next.map_request = cross_q;
        result_next.map_address = cross_q ? map_sum : '0;
      end
    end else if (full_q) begin
      result_next.status = ST_OVERFLOW;
    end else begin
      result_next.map_request = stack_map_q;
      result_next.map_address = stack_map_q ? map_sum : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_offset  <= RST_NEXT_OFF;
      free_count   <= '0;
      mapped_slots <= '0;
    end else if (cmd.cfg_we && cfg_hit) begin
      next_offset  <= OFFSET_W'(round_up(OBJ_W'(header_new), align_new));
      free_count   <= '0;
      mapped_slots <= '0;
    end else begin
      if (fresh) begin
        next_offset <= sum_q[OFFSET_W-1:0];
      end
      if (pop) begin
        free_count <= free_count - COUNT_W'(1);
      end
      if (push) begin
        free_count <= free_count + COUNT_W'(1);
        if (stack_map_q) begin
          mapped_slots <= mapped_slots + SLOTS_STEP;
        end
      end
    end
  end

  // every stacked entry sits in a page that was already requested
  a_stack_mapped: assert property (@(posedge clk) disable iff (rst)
    free_count <= mapped_slots)
    else $error("free stack entry outside mapped pages");

  // the bump pointer only moves up between reinitializations
  a_bump_monotonic: assert property (@(posedge clk) disable iff (rst)
    !cmd.cfg_we |=> next_offset >= $past(next_offset))
    else $error("bump pointer moved backward");

endmodule

`default_nettype wire

/* src/fixed_size_pool_allocator_unit.sv */
// fixed_size_pool_allocator_unit: top level of the fixed-size pool allocator
// depends on fpa_pkg, fpa_ctrl, fpa_datapath and fpa_ram
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  request channel: drive req (mode, free_address) and raise start; the
//   transfer happens on the rising edge where start is high and busy low
//  result channel: done pulses for one cycle with result valid beside it;
//   there is no back-pressure, the result must be taken in that cycle
//  config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; a write
//   to indexes 0..3 updates the register and re-initializes the pool (bump
//   pointer back to the aligned header end, free stack emptied); other
//   indexes are ignored; cfg_ready is low while busy or while start is high
//  sequencing: the accepting edge moves the sequencer to exec and reads
//   the free stack ram while flags and offsets are captured; the exec state
//   does the 64-bit base adds, registers the result and updates pointer and
//   stack, and done is registered from it; busy is high during exec, so no
//   new request is taken then, but one is taken while done is shown
//  reset: synchronous rst restores register defaults (pool 0, 64-byte
//   objects, 8-byte alignment, 40-byte header) and empties the free stack;
//   stack ram contents are not cleared, pops only reach pushed entries
module fixed_size_pool_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fpa_pkg::fpa_req_t               req,
  output logic                            done,
  output fpa_pkg::fpa_result_t            result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpa_pkg::*;

  // command group from the sequencer into the datapath
  fpa_cmd_t cmd;

  // sequencer: idle / exec, also owns the done strobe and config ready
  fpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cfg_valid(cfg_valid),
    .busy     (busy),
    .cfg_ready(cfg_ready),
    .done     (done),
    .cmd      (cmd)
  );

  // datapath: config registers, bump pointer, free stack ram, result register
  fpa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

`default_nettype wire

/* sim/fixed_size_pool_allocator_unit_test.sv */
// fixed_size_pool_allocator_unit_test: self-checking bench for the pool allocator
// shadow pool predicts every outcome, results are compared as they stream out
// depends on fpa_pkg and fixed_size_pool_allocator_unit
`timescale 1ns / 1ps

module fixed_size_pool_allocator_unit_test;
  import fpa_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int REPORT_LIMIT = 10;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 4'd15;

  localparam logic [ADDR_W-1:0] POOL_SPAN = 64'd1 << POOL_OFFSET_BITS;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  fpa_req_t               req       = '0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   busy;
  logic                   done;
  logic                   cfg_ready;
  fpa_result_t            result;

  fixed_size_pool_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the pool: registers, bump pointer and free stack
  logic [POOL_INDEX_W-1:0]     shadow_pool;
  logic [ELEM_W-1:0]           shadow_elem;
  logic [ALIGN_W-1:0]          shadow_align;
  logic [HEADER_W-1:0]         shadow_header;
  logic [ADDR_W-1:0]           bump_offset;
  logic [POOL_OFFSET_BITS-1:0] freed_offsets [FREE_DEPTH];
  int unsigned                 freed_count;
  int unsigned                 backed_slots;

  fpa_result_t       outcomes_due [$];
  fpa_result_t       last_outcome;
  logic [ADDR_W-1:0] live_objects [$];
  int                sender_idle_pct;
  int                fail_count  = 0;
  int                idle_cycles = 0;

  function automatic logic [ADDR_W-1:0] align_to(input logic [ADDR_W-1:0] value,
                                                 input int unsigned lg);
    logic [ADDR_W-1:0] mask;
    mask = (64'd1 << lg) - 64'd1;
    return (value + mask) & ~mask;
  endfunction

  function automatic void reload_pool();
    bump_offset  = align_to(64'(shadow_header), shadow_align);
    freed_count  = 0;
    backed_slots = 0;
  endfunction

  function automatic void restore_defaults();
    shadow_pool   = '0;
    shadow_elem   = RST_ELEM;
    shadow_align  = RST_ALIGN;
    shadow_header = RST_HEADER;
    reload_pool();
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_POOL_INDEX:    shadow_pool   = data[POOL_INDEX_W-1:0];
      REG_ELEMENT_BYTES: shadow_elem   = data[ELEM_W-1:0];
      REG_ALIGN_LOG2:    shadow_align  = data[ALIGN_W-1:0];
      REG_HEADER_BYTES:  shadow_header = data[HEADER_W-1:0];
      default:           return;
    endcase
    reload_pool();
  endfunction

  // outcome of one request against the shadow pool, state advanced in place
  function automatic fpa_result_t apply_request(input fpa_req_t item);
    fpa_result_t       outcome;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    outcome = '0;
    base = REGION_BASE + (64'(shadow_pool) << POOL_OFFSET_BITS);
    if (item.mode == MODE_ALLOC) begin
      if (freed_count > 0) begin
        // most recently freed object goes out first
        freed_count--;
        outcome.address = base + 64'(freed_offsets[freed_count]);
        outcome.status  = ST_REUSED;
      end else begin
        size = align_to(64'(shadow_elem), shadow_align);
        if (bump_offset + size > POOL_SPAN) begin
          outcome.status = ST_EXHAUSTED;
        end else begin
          // object straddling a page boundary asks for its start rounded up to a page
          if (size != 0 && (bump_offset >> PAGE_LOG2) !=
              ((bump_offset + size - 64'd1) >> PAGE_LOG2)) begin
            outcome.map_request = 1'b1;
            outcome.map_address = base + align_to(bump_offset, PAGE_LOG2);
          end
          outcome.address = base + bump_offset;
          outcome.status  = ST_FRESH;
          bump_offset     = bump_offset + size;
        end
      end
    end else begin
      if (freed_count >= FREE_DEPTH) begin
        outcome.status = ST_OVERFLOW;
      end else begin
        // stack grows down from the pool end, one page at a time
        if (freed_count == backed_slots) begin
          outcome.map_request = 1'b1;
          outcome.map_address = base + POOL_SPAN
                              - 64'(backed_slots * SLOT_BYTES) - 64'(PAGE_BYTES);
          backed_slots = backed_slots + SLOTS_PER_PAGE;
        end
        freed_offsets[freed_count] = item.free_address[POOL_OFFSET_BITS-1:0];
        freed_count++;
        outcome.status = ST_FREED;
      end
    end
    return outcome;
  endfunction

  // one request transfer; the outcome is queued at the accepting edge
  task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr);
    fpa_req_t item;
    item.mode         = mode;
    item.free_address = addr;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    last_outcome = apply_request(item);
    outcomes_due.push_back(last_outcome);
  endtask

  // register write, only once every outcome is back and the block is quiet
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(index, data);
    live_objects.delete();
  endtask

  task automatic note_failure(input string what, input fpa_result_t want,
                              input fpa_result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t %s: expected addr=%h st=%0d map=%b map_addr=%h,",
               $realtime, what, want.address, want.status, want.map_request,
               want.map_address,
               " got addr=%h st=%0d map=%b map_addr=%h",
               got.address, got.status, got.map_request, got.map_address);
  endtask

  // result checker, one result per done strobe
  always @(posedge clk) begin
    fpa_result_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        note_failure("result with nothing pending", '0, result);
      end else begin
        want = outcomes_due.pop_front();
        if (result.address !== want.address || result.status !== want.status ||
            result.map_request !== want.map_request ||
            result.map_address !== want.map_address)
          note_failure("result mismatch", want, result);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] draw_register_value(
      input logic [CFG_INDEX_W-1:0] index);
    logic [CFG_DATA_W-1:0] value;
    int                    pick;
    pick  = $urandom_range(3);
    value = $urandom();
    case (index)
      REG_POOL_INDEX:
        if (pick == 0) value = 32'd0;
        else if (pick == 1) value = 32'h00FF_FFFF;
      REG_ELEMENT_BYTES:
        if (pick == 0) value = 32'd1;
        else if (pick == 1) value = 32'd1048576;
        else if (pick == 2) value = $urandom_range(1, 300);
      REG_ALIGN_LOG2:
        if (pick == 0) value = 32'd0;
        else if (pick == 1) value = 32'd12;
      REG_HEADER_BYTES:
        if (pick == 0) value = 32'd0;
        else if (pick == 1) value = 32'd4095;
      default: ;
    endcase
    return value;
  endfunction

  // allocations, frees of live objects, and stray frees of any address
  task automatic run_mixed_traffic(input int count);
    int                pick;
    int                slot;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_request(MODE_ALLOC, {$urandom(), $urandom()});
      end else if (pick < 90 && live_objects.size() != 0) begin
        slot = $urandom_range(live_objects.size() - 1);
        addr = live_objects[slot];
        live_objects.delete(slot);
        send_request(MODE_FREE, addr);
      end else begin
        send_request(MODE_FREE, {$urandom(), $urandom()});
      end
      if (last_outcome.status == ST_FRESH || last_outcome.status == ST_REUSED)
        live_objects.push_back(last_outcome.address);
    end
  endtask

  // default registers: fresh objects, first stack page, foreign frees, reuse
  task automatic test_reset_defaults();
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(MODE_FREE, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
  endtask

  // register extremes, zero size, large alignment, ignored indexes
  task automatic test_register_extremes();
    write_register(REG_ELEMENT_BYTES, 32'd0);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_ELEMENT_BYTES, 32'hFFFF_FFFF);
    write_register(REG_ALIGN_LOG2, 32'd0);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_ALIGN_LOG2, 32'd12);
    write_register(REG_HEADER_BYTES, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_ALIGN_LOG2, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_ALIGN_LOG2, 32'd13);
    send_request(MODE_ALLOC, 64'd0);
    // top pool, base wraps past the top of the address space
    write_register(REG_POOL_INDEX, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_FREE, {$urandom(), $urandom()});
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_ELEMENT_BYTES, 32'd1);
    write_register(REG_ALIGN_LOG2, 32'd0);
    write_register(REG_HEADER_BYTES, 32'd0);
    send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_ALLOC, 64'd0);
    // pointer must carry on across writes past the register list
    write_register(REG_UNUSED_TOP, 32'hFFFF_FFFF);
    send_request(MODE_ALLOC, 64'd0);
    write_register(REG_UNUSED_LOW, 32'd0);
    send_request(MODE_ALLOC, 64'd0);
  endtask

  // random registers and traffic under each sender idling level
  task automatic test_random_traffic();
    int                     idle_levels [3] = '{37, 82, 0};
    logic [CFG_INDEX_W-1:0] reg_order [4] = '{REG_POOL_INDEX, REG_ELEMENT_BYTES,
                                              REG_ALIGN_LOG2, REG_HEADER_BYTES};
    logic [CFG_INDEX_W-1:0] index;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_levels[phase];
      for (int seg = 0; seg < 4; seg++) begin
        index = reg_order[(seg + phase) % 4];
        write_register(index, draw_register_value(index));
        if ($urandom_range(3) == 0)
          write_register(CFG_INDEX_W'($urandom_range(4, 15)), $urandom());
        run_mixed_traffic(8);
      end
    end
  endtask

  // fill the free stack, overflow it, pop a few; pops never unmap
  task automatic test_free_stack_limits();
    write_register(REG_POOL_INDEX, $urandom());
    write_register(REG_ELEMENT_BYTES, 32'd64);
    for (int i = 0; i < FREE_DEPTH + 2; i++)
      send_request(MODE_FREE, {$urandom(), $urandom()});
    for (int i = 0; i < 6; i++)
      send_request(MODE_ALLOC, 64'd0);
    send_request(MODE_FREE, {$urandom(), $urandom()});
    send_request(MODE_ALLOC, 64'd0);
  endtask

  initial begin
    restore_defaults();
    sender_idle_pct = 37;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_free_stack_limits();

    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
src/fpa_pkg.sv
src/fpa_ram.sv
src/fpa_ctrl.sv
src/fpa_datapath.sv
src/fixed_size_pool_allocator_unit.sv
sim/fixed_size_pool_allocator_unit_test.sv
